@@ src/sha1md_pkg.sv @@
// Shared types and constants for the SHA-1 message digest core.
// Used by sha1md_compress and sha1_message_digest_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sha1md_pkg;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned CHAIN_WORDS = 5;
    localparam int unsigned ROUNDS = 80;

    typedef logic [BLOCK_WORDS-1:0][31:0] block_t;
    typedef logic [CHAIN_WORDS-1:0][31:0] chain_t;

    // Control from the message sequencer to the compression engine.
    typedef struct packed {
        logic start;
        logic init;
    } comp_ctrl_t;

    localparam logic [31:0] K_ROUND0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

    localparam chain_t CHAIN_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LAST_BYTE_POS = 6'd63;
    localparam logic [5:0] LENGTH_BYTE_POS = 6'd56;

endpackage

`default_nettype wire

@@ src/sha1md_compress.sv @@
// SHA-1 compression engine: one round per cycle over a 16-word schedule window.
// Holds the five chaining words. Depends on sha1md_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha1md_compress
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sha1md_pkg::comp_ctrl_t ctrl,
    input  wire sha1md_pkg::block_t   block,
    output logic                      done,
    output sha1md_pkg::chain_t        chain
);

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ROUND = 3'b010,
        C_ADD   = 3'b100
    } comp_state_t;

    localparam logic [6:0] LAST_ROUND = 7'(sha1md_pkg::ROUNDS - 1);

    comp_state_t         state_reg, state_next;
    logic [6:0]          round_reg, round_next;
    sha1md_pkg::chain_t  chain_reg, chain_next;
    sha1md_pkg::block_t  win_reg, win_next;
    logic [31:0]         a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]         a_next, b_next, c_next, d_next, e_next;

    always_comb
    begin
        logic [31:0] f_val;
        logic [31:0] k_val;
        logic [31:0] sched;

        state_next = state_reg;
        round_next = round_reg;
        chain_next = chain_reg;
        win_next = win_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;

        if (round_reg inside {[7'd0:7'd19]})
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1md_pkg::K_ROUND0;
        end
        else if (round_reg inside {[7'd20:7'd39]})
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1md_pkg::K_ROUND1;
        end
        else if (round_reg inside {[7'd40:7'd59]})
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1md_pkg::K_ROUND2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1md_pkg::K_ROUND3;
        end

        sched = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];

        case (state_reg)
            C_IDLE:
            begin
                if (ctrl.init)
                begin
                    chain_next = sha1md_pkg::CHAIN_INIT;
                end
                if (ctrl.start)
                begin
                    a_next = chain_reg[0];
                    b_next = chain_reg[1];
                    c_next = chain_reg[2];
                    d_next = chain_reg[3];
                    e_next = chain_reg[4];
                    win_next = block;
                    round_next = '0;
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                a_next = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + win_reg[0];
                b_next = a_reg;
                c_next = {b_reg[1:0], b_reg[31:2]};
                d_next = c_reg;
                e_next = d_reg;
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[15] = {sched[30:0], sched[31]};
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = C_ADD;
                end
            end
            C_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            chain_reg <= sha1md_pkg::CHAIN_INIT;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

    assign done = (state_reg == C_ADD);
    assign chain = chain_reg;

endmodule

`default_nettype wire

@@ src/sha1_message_digest_core.sv @@
// Byte-stream SHA-1 core: packs message bytes, pads, and delivers the digest.
// A plain byte item is taken while in_ready stays high. The 64th byte of a block
// holds the input while it is compressed (start, rounds, final add). An end item holds
// the input while the padded block, or two when padding spills, is compressed; the five
// digest words then leave one per cycle from an output buffer while out_ready is high.
// Reset: asynchronous, active low; chaining words return to the start values, length 0.
`timescale 1ns / 1ps
`default_nettype none

module sha1_message_digest_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_valid,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    typedef enum logic [10:0] {
        S_IDLE       = 11'b00000000001,
        S_GO_DATA    = 11'b00000000010,
        S_WAIT_DATA  = 11'b00000000100,
        S_PAD        = 11'b00000001000,
        S_GO_PAD     = 11'b00000010000,
        S_WAIT_PAD   = 11'b00000100000,
        S_ZERO       = 11'b00001000000,
        S_GO_FINAL   = 11'b00010000000,
        S_WAIT_FINAL = 11'b00100000000,
        S_COPY       = 11'b01000000000,
        S_SPARE      = 11'b10000000000
    } seq_state_t;

    localparam logic [2:0] LAST_INDEX = 3'(sha1md_pkg::CHAIN_WORDS - 1);

    seq_state_t              state_reg, state_next;
    logic [63:0]             len_reg, len_next;
    logic                    end_pend_reg, end_pend_next;
    logic                    out_busy_reg, out_busy_next;
    logic [2:0]              out_idx_reg, out_idx_next;
    sha1md_pkg::block_t      block_reg, block_next;
    sha1md_pkg::chain_t      dig_reg, dig_next;
    sha1md_pkg::comp_ctrl_t  comp_ctrl;
    sha1md_pkg::chain_t      chain;
    logic                    comp_done;
    logic [5:0]              pos;
    logic                    in_fire;
    logic                    out_fire;

    sha1md_compress u_compress
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (comp_ctrl),
        .block (block_reg),
        .done  (comp_done),
        .chain (chain)
    );

    assign pos = len_reg[8:3];
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        logic [4:0]  shamt;
        logic [31:0] lane_mask;
        logic [31:0] keep_mask;

        state_next = state_reg;
        len_next = len_reg;
        end_pend_next = end_pend_reg;
        block_next = block_reg;
        dig_next = dig_reg;
        out_busy_next = out_busy_reg;
        out_idx_next = out_idx_reg;
        comp_ctrl = '0;

        shamt = {~pos[1:0], 3'b000};
        lane_mask = 32'h000000FF << shamt;
        keep_mask = ~(32'hFFFFFFFF >> {pos[1:0], 3'b000});

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (byte_valid)
                    begin
                        block_next[pos[5:2]] = (block_reg[pos[5:2]] & ~lane_mask)
                                             | ({24'd0, data_byte} << shamt);
                        len_next = len_reg + 64'd8;
                    end
                    if (byte_valid && (pos == sha1md_pkg::LAST_BYTE_POS))
                    begin
                        end_pend_next = end_of_message;
                        state_next = S_GO_DATA;
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_GO_DATA:
            begin
                comp_ctrl.start = 1'b1;
                state_next = S_WAIT_DATA;
            end
            S_WAIT_DATA:
            begin
                if (comp_done)
                begin
                    state_next = end_pend_reg ? S_PAD : S_IDLE;
                end
            end
            S_PAD:
            begin
                for (int i = 0; i < sha1md_pkg::BLOCK_WORDS; i++)
                begin
                    if (4'(i) == pos[5:2])
                    begin
                        block_next[i] = (block_reg[i] & keep_mask)
                                      | ({24'd0, sha1md_pkg::PAD_BYTE} << shamt);
                    end
                    else if (4'(i) > pos[5:2])
                    begin
                        block_next[i] = '0;
                    end
                end
                if (pos >= sha1md_pkg::LENGTH_BYTE_POS)
                begin
                    state_next = S_GO_PAD;
                end
                else
                begin
                    block_next[14] = len_reg[63:32];
                    block_next[15] = len_reg[31:0];
                    state_next = S_GO_FINAL;
                end
            end
            S_GO_PAD:
            begin
                comp_ctrl.start = 1'b1;
                state_next = S_WAIT_PAD;
            end
            S_WAIT_PAD:
            begin
                if (comp_done)
                begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                for (int i = 0; i < 14; i++)
                begin
                    block_next[i] = '0;
                end
                block_next[14] = len_reg[63:32];
                block_next[15] = len_reg[31:0];
                state_next = S_GO_FINAL;
            end
            S_GO_FINAL:
            begin
                comp_ctrl.start = 1'b1;
                state_next = S_WAIT_FINAL;
            end
            S_WAIT_FINAL:
            begin
                if (comp_done)
                begin
                    state_next = S_COPY;
                end
            end
            S_COPY:
            begin
                if (!out_busy_reg)
                begin
                    dig_next = chain;
                    out_busy_next = 1'b1;
                    out_idx_next = '0;
                    comp_ctrl.init = 1'b1;
                    len_next = '0;
                    end_pend_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_fire)
        begin
            if (out_idx_reg == LAST_INDEX)
            begin
                out_busy_next = 1'b0;
                out_idx_next = '0;
            end
            else
            begin
                out_idx_next = out_idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg <= '0;
            end_pend_reg <= 1'b0;
            out_busy_reg <= 1'b0;
            out_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg <= len_next;
            end_pend_reg <= end_pend_next;
            out_busy_reg <= out_busy_next;
            out_idx_reg <= out_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        block_reg <= block_next;
        dig_reg <= dig_next;
    end

    assign out_valid = out_busy_reg;
    assign digest_word = dig_reg[out_idx_reg];
    assign word_index = out_idx_reg;
    assign last_word = (out_idx_reg == LAST_INDEX);

endmodule

`default_nettype wire

@@ tb/sha1md_digest_checker.sv @@
// Checker for the SHA-1 message digest core: watches both channels, predicts the digest words
// from the accepted byte items, and compares every delivered word with the oldest prediction.
// Depends on nothing but the port signals of sha1_message_digest_core.
`timescale 1ns / 1ps

module sha1md_digest_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          fail_count,
    output int          pending_words,
    output int          words_checked
);

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_entry_t;

    digest_entry_t expected_digest[$];

    logic [31:0] hash_state [0:4];
    logic [31:0] msg_block [0:15];
    logic [63:0] msg_bits;

    function automatic void restart_hash();
        hash_state[0] = 32'h67452301;
        hash_state[1] = 32'hEFCDAB89;
        hash_state[2] = 32'h98BADCFE;
        hash_state[3] = 32'h10325476;
        hash_state[4] = 32'hC3D2E1F0;
        msg_bits = 64'd0;
    endfunction

    function automatic void put_byte(input int pos, input logic [7:0] value);
        msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = value;
    endfunction

    function automatic void fold_block();
        logic [31:0] w [0:79];
        logic [31:0] a, b, c, d, e, f, k, t;
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int i = 0; i < 16; i++)
            w[i] = msg_block[i];
        for (int i = 16; i < 80; i++)
        begin
            t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {t[30:0], t[31]};
        end
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_state[0] = hash_state[0] + a;
        hash_state[1] = hash_state[1] + b;
        hash_state[2] = hash_state[2] + c;
        hash_state[3] = hash_state[3] + d;
        hash_state[4] = hash_state[4] + e;
    endfunction

    function automatic void absorb_item(input logic [7:0] value, input logic has_byte,
                                        input logic closes);
        int pos;
        logic [63:0] total_bits;
        digest_entry_t entry;
        if (has_byte)
        begin
            pos = int'(msg_bits[8:3]);
            put_byte(pos, value);
            msg_bits = msg_bits + 64'd8;
            if (pos == 63)
                fold_block();
        end
        if (closes)
        begin
            total_bits = msg_bits;
            pos = int'(msg_bits[8:3]);
            put_byte(pos, 8'h80);
            pos++;
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    put_byte(pos, 8'h00);
                    pos++;
                end
                fold_block();
                pos = 0;
            end
            while (pos < 56)
            begin
                put_byte(pos, 8'h00);
                pos++;
            end
            msg_block[14] = total_bits[63:32];
            msg_block[15] = total_bits[31:0];
            fold_block();
            for (int i = 0; i < 5; i++)
            begin
                entry.word = hash_state[i];
                entry.index = 3'(i);
                entry.last = (i == 4);
                expected_digest.push_back(entry);
            end
            restart_hash();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digest_entry_t want;
        if (!rst_n)
        begin
            expected_digest.delete();
            restart_hash();
            for (int i = 0; i < 16; i++)
                msg_block[i] = 32'd0;
            pending_words = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_item(data_byte, byte_valid, end_of_message);
            if (out_valid && out_ready)
            begin
                if (expected_digest.size() == 0)
                begin
                    $error("digest_word %h (word_index %0d) arrived with nothing expected",
                           digest_word, word_index);
                    fail_count++;
                end
                else
                begin
                    want = expected_digest.pop_front();
                    words_checked++;
                    if (digest_word !== want.word)
                    begin
                        $error("digest_word: expected %h, got %h", want.word, digest_word);
                        fail_count++;
                    end
                    if (word_index !== want.index)
                    begin
                        $error("word_index: expected %0d, got %0d", want.index, word_index);
                        fail_count++;
                    end
                    if (last_word !== want.last)
                    begin
                        $error("last_word: expected %0b, got %0b", want.last, last_word);
                        fail_count++;
                    end
                end
            end
            pending_words = expected_digest.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// Top of the SHA-1 message digest testbench: clock, reset, byte stream and output stalls.
// Instantiates sha1_message_digest_core and sha1md_digest_checker, and gives the verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 380;
    localparam int MIN_MESSAGES = 6;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        end_of_message;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    int fail_count;
    int pending_words;
    int words_checked;
    int items_sent;
    int messages_sent;
    int stall_cycles;
    bit calm;

    sha1_message_digest_core dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    sha1md_digest_checker digest_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word),
        .fail_count     (fail_count),
        .pending_words  (pending_words),
        .words_checked  (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= calm || ($urandom_range(0, 99) >= 33);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no item moved for %0d cycles.", STALL_LIMIT);
            $display("** sha1_message_digest_core: FAILED **");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_item(input logic [7:0] value, input logic has_byte, input logic closes);
        while (!calm && $urandom_range(0, 99) < 33)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= value;
        byte_valid <= has_byte;
        end_of_message <= closes;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        if (has_byte || closes)
            items_sent++;
        if (closes)
            messages_sent++;
    endtask

    task automatic wait_for_digests();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_words != 0);
    endtask

    task automatic send_message(input int length, input bit separate_end);
        int fill;
        logic [7:0] value;
        fill = $urandom_range(0, 7);
        for (int i = 0; i < length; i++)
        begin
            if (fill == 0)
                value = 8'h00;
            else if (fill == 1)
                value = 8'hFF;
            else
                value = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 6)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(value, 1'b1, (i == length - 1) && !separate_end);
        end
        if (length == 0 || separate_end)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    function automatic int pick_length(input int msg_number);
        case (msg_number)
            0: return 55;
            1: return 56;
            2: return 63;
            3: return 64;
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(1, 70);
            4:
            begin
                case ($urandom_range(0, 7))
                    0: return 55;
                    1: return 56;
                    2: return 57;
                    3: return 63;
                    4: return 64;
                    5: return 65;
                    6: return 119;
                    default: return 120;
                endcase
            end
            5: return $urandom_range(0, 2);
            6: return $urandom_range(100, 140);
            default: return $urandom_range(0, 64);
        endcase
    endfunction

    initial
    begin
        int base_items;
        int base_messages;
        int msg_number;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        byte_valid = 1'b0;
        end_of_message = 1'b0;
        calm = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Idle item, empty message, single extreme bytes, "abc", and a late end item.
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        wait_for_digests();
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        wait_for_digests();

        base_items = items_sent;
        base_messages = messages_sent;
        msg_number = 0;
        while (items_sent - base_items < RANDOM_ITEMS ||
               messages_sent - base_messages < MIN_MESSAGES)
        begin
            calm = (msg_number >= 5 && msg_number < 9);
            send_message(pick_length(msg_number), $urandom_range(0, 3) == 0);
            if (msg_number % 4 == 3)
                wait_for_digests();
            msg_number++;
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_words != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);

        $display("Hashed %0d messages from %0d byte and end items; %0d digest words compared.",
                 messages_sent, items_sent, words_checked);
        if (fail_count == 0 && pending_words == 0)
            $display("** sha1_message_digest_core: PASSED **");
        else
            $display("** sha1_message_digest_core: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
src/sha1md_pkg.sv
src/sha1md_compress.sv
src/sha1_message_digest_core.sv
tb/sha1md_digest_checker.sv
tb/tb_top.sv
